@@ sv/dtw_pkg.sv @@
`default_nettype none
package dtw_pkg;

  // input beat kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_TOUCH = 2'd1,
    KIND_HW    = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_ENABLE  = 2'd0,
    CFG_ARMED   = 2'd1,
    CFG_FEATHER = 2'd2,
    CFG_WINDOW  = 2'd3
  } cfg_idx_t;

  localparam int CFG_DATA_W = 16;

  // multitouch event codes
  localparam logic [9:0] CODE_SLOT   = 10'd47;
  localparam logic [9:0] CODE_X      = 10'd53;
  localparam logic [9:0] CODE_Y      = 10'd54;
  localparam logic [9:0] CODE_TRACK  = 10'd57;
  localparam logic [9:0] CODE_BUTTON = 10'd330;

  localparam logic [31:0] TRACK_LIFT = 32'hFFFF_FFFF;

  localparam logic [15:0] FEATHER_RESET = 16'd50;
  localparam logic [15:0] WINDOW_RESET  = 16'd600;

  localparam logic WAKE_SW = 1'b0;
  localparam logic WAKE_HW = 1'b1;

endpackage
`default_nettype wire

@@ sv/dtw_if.sv @@
`default_nettype none
interface dtw_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [9:0]         event_code;
  logic signed [31:0] event_value;

  modport source (output valid, output kind, output event_code, output event_value,
                  input ready);
  modport sink (input valid, input kind, input event_code, input event_value,
                output ready);
endinterface

interface dtw_out_if;
  logic valid;
  logic ready;
  logic wake_source;

  modport source (output valid, output wake_source, input ready);
  modport sink (input valid, input wake_source, output ready);
endinterface
`default_nettype wire

@@ sv/double_tap_wake_detector_core.sv @@
// An accepted input beat reaches its result beat through the input register, then
// the result register. Throughput: one input beat per cycle; the input side only
// stalls when a result-producing beat meets a full, unacknowledged result register.
// Reset (rst, synchronous, active high) clears the pipeline, the ms counter and the
// tap state and loads the configuration defaults.
`default_nettype none
module double_tap_wake_detector_core #(
  parameter int TIME_BITS = 32
) (
  input  wire                            clk,
  input  wire                            rst,
  dtw_in_if.sink                         in_ch,
  dtw_out_if.source                      out_ch,
  input  wire                            cfg_we,
  input  wire [1:0]                      cfg_index,
  input  wire [dtw_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // configuration
  logic        enable;
  logic        armed;
  logic [15:0] feather_distance;
  logic [15:0] tap_window_ms;

  // detector state
  logic [TIME_BITS-1:0] ms_counter;
  logic [31:0]          latched_x;
  logic [31:0]          latched_y;
  logic                 contact_open;
  logic [1:0]           tap_count;
  logic [31:0]          first_x;
  logic [31:0]          first_y;
  logic [TIME_BITS-1:0] first_time;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_kind;
  logic [9:0]  s1_code;
  logic [31:0] s1_value;

  // result register
  logic out_valid;
  logic out_wake;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable           <= 1'b0;
      armed            <= 1'b0;
      feather_distance <= dtw_pkg::FEATHER_RESET;
      tap_window_ms    <= dtw_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (dtw_pkg::cfg_idx_t'(cfg_index))
        dtw_pkg::CFG_ENABLE:  enable           <= cfg_data[0];
        dtw_pkg::CFG_ARMED:   armed            <= cfg_data[0];
        dtw_pkg::CFG_FEATHER: feather_distance <= cfg_data[15:0];
        dtw_pkg::CFG_WINDOW:  tap_window_ms    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1 decode ----------------
  logic is_tick, is_hw, is_touch;
  logic is_slot, is_lift, is_x, is_y;
  logic tap_hit;
  logic [31:0] new_x, new_y;
  logic [32:0] dx, dy, mag_x, mag_y;
  logic [TIME_BITS-1:0] dt;
  logic match;
  logic s1_has_res;
  logic s1_res_wake;
  logic s1_go;

  always_comb begin
    is_tick  = s1_kind == dtw_pkg::KIND_TICK;
    is_hw    = s1_kind == dtw_pkg::KIND_HW;
    is_touch = (s1_kind == dtw_pkg::KIND_TOUCH) && armed;

    is_slot = is_touch && s1_code == dtw_pkg::CODE_SLOT;
    is_lift = is_touch &&
              ((s1_code == dtw_pkg::CODE_TRACK && s1_value == dtw_pkg::TRACK_LIFT) ||
               (s1_code == dtw_pkg::CODE_BUTTON && s1_value == 32'd0));
    is_x    = is_touch && s1_code == dtw_pkg::CODE_X;
    is_y    = is_touch && s1_code == dtw_pkg::CODE_Y;

    new_x = is_x ? s1_value : latched_x;
    new_y = is_y ? s1_value : latched_y;

    tap_hit = (is_x || is_y) && enable && contact_open;

    // exact signed distance on 33 bits
    dx    = {new_x[31], new_x} - {first_x[31], first_x};
    dy    = {new_y[31], new_y} - {first_y[31], first_y};
    mag_x = dx[32] ? (33'd0 - dx) : dx;
    mag_y = dy[32] ? (33'd0 - dy) : dy;
    dt    = ms_counter - first_time;

    match = tap_count == 2'd1 &&
            mag_x < {17'd0, feather_distance} &&
            mag_y < {17'd0, feather_distance} &&
            dt < TIME_BITS'(tap_window_ms);

    s1_has_res  = (is_hw && enable && armed) || (tap_hit && match);
    s1_res_wake = is_hw ? dtw_pkg::WAKE_HW : dtw_pkg::WAKE_SW;

    s1_go = s1_valid && (!s1_has_res || !out_valid || out_ch.ready);
  end

  assign in_ch.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_kind  <= in_ch.kind;
      s1_code  <= in_ch.event_code;
      s1_value <= in_ch.event_value;
    end
  end

  // state update when the stage-1 beat retires
  always_ff @(posedge clk) begin
    if (rst) begin
      ms_counter   <= '0;
      latched_x    <= '0;
      latched_y    <= '0;
      contact_open <= 1'b1;
      tap_count    <= '0;
      first_x      <= '0;
      first_y      <= '0;
      first_time   <= '0;
    end else if (s1_go) begin
      if (is_tick) begin
        ms_counter <= ms_counter + TIME_BITS'(1);
      end
      latched_x <= new_x;
      latched_y <= new_y;
      if (is_lift) begin
        contact_open <= 1'b1;
      end else if (tap_hit) begin
        contact_open <= 1'b0;
      end
      if (is_slot || (tap_hit && match)) begin
        tap_count  <= '0;
        first_x    <= '0;
        first_y    <= '0;
        first_time <= '0;
      end else if (tap_hit) begin
        // any unmatched tap becomes the new first tap
        tap_count  <= 2'd1;
        first_x    <= new_x;
        first_y    <= new_y;
        first_time <= ms_counter;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_has_res) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_has_res) begin
      out_wake <= s1_res_wake;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.wake_source = out_wake;

endmodule
`default_nettype wire

@@ sv/dtw_checker.sv @@
`default_nettype none
module dtw_checker (
  input wire clk,
  input wire rst,
  input wire in_valid,
  input wire in_ready,
  input wire out_valid,
  input wire out_ready,
  input wire out_wake
);

  // result beat held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_wake))
    else $error("result payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

  // a fresh result always follows an accepted input beat, via the input and result registers
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding input beat");

endmodule

bind double_tap_wake_detector_core dtw_checker u_dtw_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_wake  (out_ch.wake_source)
);
`default_nettype wire

@@ tb/sv/double_tap_wake_detector_core_tb.sv @@
`timescale 1ns / 1ps
module double_tap_wake_detector_core_tb;

  localparam int IDLE_PCT    = 16;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE      = 6;

  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  code;
    logic [31:0] value;
  } beat_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [1:0]                     cfg_index = dtw_pkg::CFG_ENABLE;
  logic [dtw_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  dtw_in_if  in_ch ();
  dtw_out_if out_ch ();

  double_tap_wake_detector_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // detector shadow: settings and gesture state
  logic        sh_enable, sh_armed;
  logic [15:0] sh_feather, sh_window;
  logic [31:0] ms_now, lat_x, lat_y, tap_x, tap_y, tap_time;
  logic        contact_open;
  logic [1:0]  tap_count;

  beat_t pending_beats[$];
  logic  wake_expect_q[$];
  int    errors = 0;
  int    quiet = 0;
  bit    no_idle = 1'b0;
  bit    hold_go = 1'b0;
  bit    sink_hold = 1'b0;

  initial begin
    in_ch.valid       = 1'b0;
    in_ch.kind        = dtw_pkg::KIND_TICK;
    in_ch.event_code  = '0;
    in_ch.event_value = '0;
    out_ch.ready      = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------- prediction ----------------

  function automatic longint axis_gap(logic [31:0] a, logic [31:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    return (d < 0) ? -d : d;
  endfunction

  function automatic void clear_taps();
    tap_count = '0;
    tap_time  = '0;
    tap_x     = '0;
    tap_y     = '0;
  endfunction

  function automatic void open_tap();
    tap_time  = ms_now;
    tap_x     = lat_x;
    tap_y     = lat_y;
    tap_count = tap_count + 2'd1;
  endfunction

  // 1 when this tap completes a double tap
  function automatic bit land_tap();
    logic [31:0] dt;
    dt = ms_now - tap_time;
    if (tap_count == 2'd0) begin
      open_tap();
    end else if (tap_count == 2'd1 && axis_gap(lat_x, tap_x) < sh_feather &&
                 axis_gap(lat_y, tap_y) < sh_feather && dt < sh_window) begin
      clear_taps();
      return 1'b1;
    end else begin
      clear_taps();
      open_tap();
    end
    return 1'b0;
  endfunction

  function automatic void predict_beat(beat_t b);
    if (b.kind == dtw_pkg::KIND_TICK) begin
      ms_now = ms_now + 32'd1;
    end else if (b.kind == dtw_pkg::KIND_HW) begin
      if (sh_enable && sh_armed) wake_expect_q.push_back(dtw_pkg::WAKE_HW);
    end else if (b.kind == dtw_pkg::KIND_TOUCH && sh_armed) begin
      if (b.code == dtw_pkg::CODE_SLOT) begin
        clear_taps();
      end else if ((b.code == dtw_pkg::CODE_TRACK && b.value == dtw_pkg::TRACK_LIFT) ||
                   (b.code == dtw_pkg::CODE_BUTTON && b.value == '0)) begin
        contact_open = 1'b1;
      end else if (b.code == dtw_pkg::CODE_X || b.code == dtw_pkg::CODE_Y) begin
        if (b.code == dtw_pkg::CODE_X) lat_x = b.value;
        else lat_y = b.value;
        if (sh_enable && contact_open) begin
          contact_open = 1'b0;
          if (land_tap()) wake_expect_q.push_back(dtw_pkg::WAKE_SW);
        end
      end
    end
  endfunction

  // ---------------- driver / monitor ----------------

  always @(posedge clk) begin
    beat_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        predict_beat({in_ch.kind, in_ch.event_code, in_ch.event_value});
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_beats.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          nxt = pending_beats.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.kind        <= nxt.kind;
          in_ch.event_code  <= nxt.code;
          in_ch.event_value <= nxt.value;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (wake_expect_q.size() == 0) begin
          if (errors < 10) $display("unexpected wake beat: source %0b", out_ch.wake_source);
          errors++;
        end else begin
          want = wake_expect_q.pop_front();
          if (out_ch.wake_source !== want) begin
            if (errors < 10)
              $display("wake_source mismatch: expected %0b got %0b", want, out_ch.wake_source);
            errors++;
          end
        end
      end
      out_ch.ready <= !sink_hold && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // long receiver hold-off so the result register backs up into the input
  initial begin
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------- stimulus ----------------

  function automatic void queue_beat(logic [1:0] kind, logic [9:0] code, logic [31:0] value);
    beat_t b;
    b.kind  = kind;
    b.code  = code;
    b.value = value;
    pending_beats.push_back(b);
  endfunction

  function automatic void queue_tap(logic [31:0] x, logic [31:0] y, int gap);
    if ($urandom_range(3) == 0)
      queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_TRACK, $urandom_range(500));
    if ($urandom_range(1)) begin
      queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_X, x);
      queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_Y, y);
    end else begin
      queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_Y, y);
      queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_X, x);
    end
    if ($urandom_range(1))
      queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_TRACK, dtw_pkg::TRACK_LIFT);
    else queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_BUTTON, '0);
    repeat (gap) queue_beat(dtw_pkg::KIND_TICK, '0, '0);
  endfunction

  function automatic void queue_noise();
    logic [1:0]  kind;
    logic [9:0]  code;
    logic [31:0] value;
    case ($urandom_range(5))
      0:       code = dtw_pkg::CODE_SLOT;
      1:       code = dtw_pkg::CODE_X;
      2:       code = dtw_pkg::CODE_Y;
      3:       code = dtw_pkg::CODE_TRACK;
      4:       code = dtw_pkg::CODE_BUTTON;
      default: code = 10'($urandom);
    endcase
    case ($urandom_range(3))
      0:       value = dtw_pkg::TRACK_LIFT;
      1:       value = '0;
      default: value = $urandom;
    endcase
    kind = ($urandom_range(2) == 0) ? 2'($urandom_range(3)) : dtw_pkg::KIND_TOUCH;
    queue_beat(kind, code, value);
  endfunction

  // mostly tap pairs near each other, some noise and stray slot resets
  function automatic void queue_session(int n_beats);
    int          stop_at, reach, span, dx, dy;
    logic [31:0] bx, by;
    stop_at = pending_beats.size() + n_beats;
    reach   = int'(sh_feather) + 2;
    span    = (sh_window < 16'd12) ? int'(sh_window) + 2 : 12;
    while (pending_beats.size() < stop_at) begin
      if ($urandom_range(9) < 3) begin
        queue_noise();
      end else begin
        bx = ($urandom_range(7) == 0) ? $urandom : $urandom_range(4000);
        by = ($urandom_range(7) == 0) ? $urandom : $urandom_range(4000);
        dx = int'($urandom_range(2 * reach)) - reach;
        dy = int'($urandom_range(2 * reach)) - reach;
        if ($urandom_range(9) == 0)
          queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_SLOT, '0);
        queue_tap(bx, by, $urandom_range(span));
        queue_tap(bx + 32'(dx), by + 32'(dy), $urandom_range(3));
      end
    end
  endfunction

  task automatic put_reg(dtw_pkg::cfg_idx_t idx, logic [dtw_pkg::CFG_DATA_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    case (idx)
      dtw_pkg::CFG_ENABLE:  sh_enable  = v[0];
      dtw_pkg::CFG_ARMED:   sh_armed   = v[0];
      dtw_pkg::CFG_FEATHER: sh_feather = v;
      dtw_pkg::CFG_WINDOW:  sh_window  = v;
      default: ;
    endcase
  endtask

  task automatic load_settings(logic en, logic arm, logic [15:0] feather,
                               logic [15:0] window);
    put_reg(dtw_pkg::CFG_ENABLE, {15'd0, en});
    put_reg(dtw_pkg::CFG_ARMED, {15'd0, arm});
    put_reg(dtw_pkg::CFG_FEATHER, feather);
    put_reg(dtw_pkg::CFG_WINDOW, window);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // sender holds off until every beat is in and every wake has come back
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_ch.valid || wake_expect_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    sh_enable    = 1'b0;
    sh_armed     = 1'b0;
    sh_feather   = dtw_pkg::FEATHER_RESET;
    sh_window    = dtw_pkg::WINDOW_RESET;
    ms_now       = '0;
    lat_x        = '0;
    lat_y        = '0;
    contact_open = 1'b1;
    clear_taps();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: disarmed, so only the tick counts
    queue_beat(dtw_pkg::KIND_HW, '0, '0);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_X, 32'd5);
    queue_beat(dtw_pkg::KIND_TICK, '0, '0);
    queue_beat(KIND_UNUSED, 10'h3FF, dtw_pkg::TRACK_LIFT);
    wait_drained();

    load_settings(1'b1, 1'b1, dtw_pkg::FEATHER_RESET, dtw_pkg::WINDOW_RESET);
    queue_beat(dtw_pkg::KIND_HW, '0, '0);
    queue_beat(KIND_UNUSED, 10'h3FF, dtw_pkg::TRACK_LIFT);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_TRACK, 32'd7);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_X, 32'd100);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_Y, 32'd20);
    queue_beat(dtw_pkg::KIND_TICK, '0, '0);
    queue_beat(dtw_pkg::KIND_TICK, '0, '0);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_BUTTON, 32'd1);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_BUTTON, '0);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_Y, 32'd30);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_TRACK, dtw_pkg::TRACK_LIFT);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_X, 32'h7FFF_FFFF);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_TRACK, dtw_pkg::TRACK_LIFT);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_X, 32'h8000_0000); // full-range gap
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_SLOT, '0);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_TRACK, dtw_pkg::TRACK_LIFT);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_X, 32'h8000_0031);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_TRACK, dtw_pkg::TRACK_LIFT);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_X, 32'h8000_0000);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_TRACK, dtw_pkg::TRACK_LIFT);
    queue_beat(dtw_pkg::KIND_TOUCH, dtw_pkg::CODE_Y, 32'hFFFF_FFFF);
    queue_beat(dtw_pkg::KIND_TOUCH, 10'h3FF, '0);
    wait_drained();

    no_idle = 1'b1;
    queue_session(80);
    wait_drained();
    no_idle = 1'b0;

    load_settings(1'b1, 1'b1, 16'd1, 16'd1);
    queue_session(60);
    wait_drained();

    load_settings(1'b1, 1'b1, 16'hFFFF, 16'hFFFF);
    queue_session(60);
    wait_drained();

    // zero feather and window: second taps never match
    load_settings(1'b1, 1'b1, 16'd0, 16'd0);
    queue_session(40);
    wait_drained();

    load_settings(1'b0, 1'b1, 16'd200, 16'd8);
    queue_session(40);
    wait_drained();

    load_settings(1'b1, 1'b0, 16'd200, 16'd8);
    queue_session(40);
    wait_drained();

    load_settings(1'b1, 1'b1, 16'($urandom_range(300, 2)), 16'($urandom_range(12, 2)));
    hold_go = 1'b1;
    repeat (30) queue_beat(dtw_pkg::KIND_HW, '0, '0);
    queue_session(80);
    wait_drained();

    load_settings(1'b1, 1'b1, 16'($urandom_range(300, 2)), 16'($urandom_range(12, 2)));
    queue_session(80);
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/dtw_pkg.sv
sv/dtw_if.sv
sv/double_tap_wake_detector_core.sv
sv/dtw_checker.sv
tb/sv/double_tap_wake_detector_core_tb.sv
